### rtl/i2cblm_pkg.sv
`timescale 1ns / 1ps

package i2cblm_pkg;

    // Command codes carried on the command channel
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_RDACK = 3'd4;
    localparam logic [2:0] CMD_RDNAK = 3'd5;

    // Segment lengths in delay units, stored as length minus one
    localparam logic [2:0] LONG_M1  = 3'd4;
    localparam logic [2:0] SHORT_M1 = 3'd1;

    // Register map (word index taken from paddr[2])
    localparam logic REG_TICKS = 1'b0;
    localparam logic REG_POLL  = 1'b1;

    localparam logic [15:0] TICKS_RESET = 16'd50;
    localparam logic [7:0]  POLL_RESET  = 8'd250;

    // Bus sequencer phases
    typedef enum logic [4:0] {
        PH_IDLE,
        PH_ST_A,
        PH_ST_B,
        PH_SP_A,
        PH_SP_B,
        PH_WR_D,
        PH_WR_H,
        PH_WR_L,
        PH_ACK_H,
        PH_POLL,
        PH_RD_L,
        PH_RD_H,
        PH_AK_A,
        PH_AK_B
    } phase_t;

    // One result word, values after the tick
    typedef struct packed {
        logic       ack_error;
        logic [7:0] rx_byte;
        logic       done_res;
        logic       busy_res;
        logic       sda_released;
        logic       scl_level;
    } res_t;

endpackage

### rtl/i2c_bit_level_master.sv
`timescale 1ns / 1ps

// I2C byte-level master, one bus tick per input word.
// Input stream (s_*): each word is one tick of the sequencer. s_tuser carries
// the command (none, start, stop, write+ACK check, read+ACK, read+NACK),
// s_tdata the byte to send and the SDA sample of this tick. A command is taken
// only while the sequencer is idle; commands during a transfer are ignored.
// Output stream (m_*): exactly one result word per input word, holding the
// SCL/SDA levels after the tick, busy, a done pulse, the last read byte and the
// ACK timeout flag.
// The result of an accepted word is registered and is on m_* from the next
// cycle. One word is accepted every cycle while the receiver takes results;
// the state update is a single pass into the result register.
// When the receiver stalls, the result register holds and s_tready drops
// until the result is taken, so no tick is lost.
// APB port: register 0 (byte 0x0) ticks per delay unit, register 1 (0x4) ACK
// poll limit. Write only while idle.
// Reset: sequencer idle, both lines released high, registers at 50 and 250,
// no result pending.
module i2c_bit_level_master
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // tick input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] tx_byte, [8] sda_sample, [15:9] zero
    input  logic [2:0]  s_tuser,   // [2:0] mode
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] scl_level, [1] sda_released, [2] busy_res,
                                   // [3] done_res, [11:4] rx_byte, [12] ack_error,
                                   // [15:13] zero
);

    import i2cblm_pkg::*;

    logic [15:0] ticks_reg;
    logic [7:0]  poll_reg;
    logic        m_valid_reg;
    res_t        res_reg;
    res_t        res_next;
    logic        accept;
    logic        cfg_wr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ticks_reg <= TICKS_RESET;
            poll_reg  <= POLL_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_TICKS: ticks_reg <= pwdata[15:0];
                REG_POLL:  poll_reg  <= pwdata[7:0];
                default:   ticks_reg <= ticks_reg;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (paddr[2])
            REG_TICKS: prdata = {16'd0, ticks_reg};
            REG_POLL:  prdata = {24'd0, poll_reg};
            default:   prdata = 32'd0;
        endcase
    end

    i2cblm_seq u_seq
    (
        .clk                  (clk),
        .rst_n                (rst_n),
        .step                 (accept),
        .mode                 (s_tuser),
        .tx_byte              (s_tdata[7:0]),
        .sda_sample           (s_tdata[8]),
        .ticks_per_delay_unit (ticks_reg),
        .ack_poll_limit       (poll_reg),
        .res_next             (res_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
            res_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                m_valid_reg <= 1'b1;
                res_reg     <= res_next;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'd0, res_reg.ack_error, res_reg.rx_byte, res_reg.done_res,
                       res_reg.busy_res, res_reg.sda_released, res_reg.scl_level};

`ifndef SYNTHESIS
    // a finished command is never reported busy
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_reg.done_res |-> !res_reg.busy_res)
        else $error("done with busy set");

    // a new result only appears after an accepted word
    a_rise_acc: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(accept))
        else $error("result without input word");

    // the read byte only changes together with a done pulse
    a_rx_done: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(rst_n) && res_reg.rx_byte != $past(res_reg.rx_byte)) |-> res_reg.done_res)
        else $error("rx byte changed without done");
`endif

endmodule

### rtl/i2cblm_seq.sv
`timescale 1ns / 1ps

module i2cblm_seq
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [2:0]         mode,
    input  logic [7:0]         tx_byte,
    input  logic               sda_sample,
    input  logic [15:0]        ticks_per_delay_unit,
    input  logic [7:0]         ack_poll_limit,
    output i2cblm_pkg::res_t   res_next
);

    import i2cblm_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [2:0]  cmd_reg, cmd_next;
    logic [3:0]  bit_reg, bit_next;
    logic [7:0]  shift_reg, shift_next;
    logic [15:0] delay_reg, delay_next;
    logic [2:0]  unit_reg, unit_next;
    logic [7:0]  poll_reg, poll_next;
    logic        scl_reg, scl_next;
    logic        sda_reg, sda_next;
    logic [7:0]  rx_reg, rx_next;
    logic        err_reg, err_next;

    // control decoded from the phase
    logic        fin;
    logic        goto_en;
    phase_t      goto_ph;
    logic        cmd_load;
    logic        dly_dec;
    logic        unit_dec;
    logic        bit_inc;
    logic        shift_wr;
    logic        scl_clear;
    logic        rx_load;
    logic        err_set;
    logic        poll_clear;
    logic        poll_inc;

    logic [15:0] reload;
    logic [7:0]  poll_eff;
    logic [3:0]  bit_plus;

    // a zero unit length counts as one tick
    assign reload   = (ticks_per_delay_unit == 16'd0) ? 16'd0 : ticks_per_delay_unit - 16'd1;
    assign poll_eff = (phase_reg == PH_ACK_H) ? 8'd0 : poll_reg;
    assign bit_plus = bit_reg + 4'd1;

    // next phase and control
    always_comb
    begin
        fin        = 1'b0;
        goto_en    = 1'b0;
        goto_ph    = PH_IDLE;
        cmd_load   = 1'b0;
        dly_dec    = 1'b0;
        unit_dec   = 1'b0;
        bit_inc    = 1'b0;
        shift_wr   = 1'b0;
        scl_clear  = 1'b0;
        rx_load    = 1'b0;
        err_set    = 1'b0;
        poll_clear = 1'b0;
        poll_inc   = 1'b0;
        phase_next = phase_reg;
        if (step)
        begin
            if (phase_reg == PH_IDLE)
            begin
                case (mode)
                    CMD_START:
                    begin
                        cmd_load = 1'b1;
                        goto_en  = 1'b1;
                        goto_ph  = PH_ST_A;
                    end
                    CMD_STOP:
                    begin
                        cmd_load = 1'b1;
                        goto_en  = 1'b1;
                        goto_ph  = PH_SP_A;
                    end
                    CMD_WRITE:
                    begin
                        cmd_load = 1'b1;
                        goto_en  = 1'b1;
                        goto_ph  = PH_WR_D;
                    end
                    CMD_RDACK, CMD_RDNAK:
                    begin
                        cmd_load = 1'b1;
                        goto_en  = 1'b1;
                        goto_ph  = PH_RD_L;
                    end
                    default:
                    begin
                        cmd_load = 1'b0;
                    end
                endcase
            end
            else if (phase_reg != PH_POLL && delay_reg != 16'd0)
            begin
                dly_dec = 1'b1;
            end
            else if (phase_reg != PH_POLL && unit_reg != 3'd0)
            begin
                unit_dec = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_ST_A:
                    begin
                        goto_en = 1'b1;
                        goto_ph = PH_ST_B;
                    end
                    PH_ST_B:
                    begin
                        scl_clear = 1'b1;
                        fin       = 1'b1;
                    end
                    PH_SP_A:
                    begin
                        goto_en = 1'b1;
                        goto_ph = PH_SP_B;
                    end
                    PH_SP_B:
                    begin
                        fin = 1'b1;
                    end
                    PH_WR_D:
                    begin
                        goto_en = 1'b1;
                        goto_ph = PH_WR_H;
                    end
                    PH_WR_H:
                    begin
                        goto_en = 1'b1;
                        goto_ph = PH_WR_L;
                    end
                    PH_WR_L:
                    begin
                        bit_inc  = 1'b1;
                        shift_wr = 1'b1;
                        goto_en  = 1'b1;
                        goto_ph  = bit_plus[3] ? PH_ACK_H : PH_WR_D;
                    end
                    PH_ACK_H, PH_POLL:
                    begin
                        // one ACK poll per tick
                        phase_next = PH_POLL;
                        poll_clear = (phase_reg == PH_ACK_H);
                        if (!sda_sample)
                        begin
                            scl_clear = 1'b1;
                            fin       = 1'b1;
                        end
                        else if (poll_eff >= ack_poll_limit)
                        begin
                            err_set = 1'b1;
                            goto_en = 1'b1;
                            goto_ph = PH_SP_A;
                        end
                        else
                        begin
                            poll_inc = 1'b1;
                        end
                    end
                    PH_RD_L:
                    begin
                        goto_en = 1'b1;
                        goto_ph = PH_RD_H;
                    end
                    PH_RD_H:
                    begin
                        bit_inc = 1'b1;
                        goto_en = 1'b1;
                        goto_ph = bit_plus[3] ? PH_AK_A : PH_RD_L;
                    end
                    PH_AK_A:
                    begin
                        goto_en = 1'b1;
                        goto_ph = PH_AK_B;
                    end
                    PH_AK_B:
                    begin
                        scl_clear = 1'b1;
                        rx_load   = 1'b1;
                        fin       = 1'b1;
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            if (fin)
            begin
                phase_next = PH_IDLE;
            end
            if (goto_en)
            begin
                phase_next = goto_ph;
            end
        end
    end

    // lines, counters and data
    always_comb
    begin
        cmd_next   = cmd_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        delay_next = delay_reg;
        unit_next  = unit_reg;
        poll_next  = poll_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        rx_next    = rx_reg;
        err_next   = err_reg;
        if (cmd_load)
        begin
            cmd_next = mode;
            bit_next = 4'd0;
            if (mode == CMD_WRITE)
            begin
                shift_next = tx_byte;
                err_next   = 1'b0;
            end
            else if (mode == CMD_RDACK || mode == CMD_RDNAK)
            begin
                shift_next = 8'd0;
            end
        end
        if (dly_dec)
        begin
            delay_next = delay_reg - 16'd1;
        end
        if (unit_dec)
        begin
            unit_next  = unit_reg - 3'd1;
            delay_next = reload;
        end
        if (bit_inc)
        begin
            bit_next = bit_plus;
        end
        if (shift_wr)
        begin
            shift_next = {shift_reg[6:0], 1'b0};
        end
        if (poll_clear)
        begin
            poll_next = 8'd0;
        end
        if (poll_inc)
        begin
            poll_next = poll_eff + 8'd1;
        end
        if (scl_clear)
        begin
            scl_next = 1'b0;
        end
        if (rx_load)
        begin
            rx_next = shift_reg;
        end
        if (err_set)
        begin
            err_next = 1'b1;
        end
        // segment entry: set lines and load the delay
        if (goto_en)
        begin
            delay_next = reload;
            unit_next  = SHORT_M1;
            case (goto_ph)
                PH_ST_A:
                begin
                    sda_next  = 1'b1;
                    scl_next  = 1'b1;
                    unit_next = LONG_M1;
                end
                PH_ST_B:
                begin
                    sda_next  = 1'b0;
                    unit_next = LONG_M1;
                end
                PH_SP_A:
                begin
                    scl_next  = 1'b0;
                    sda_next  = 1'b0;
                    unit_next = LONG_M1;
                end
                PH_SP_B:
                begin
                    scl_next  = 1'b1;
                    sda_next  = 1'b1;
                    unit_next = LONG_M1;
                end
                PH_WR_D:
                begin
                    scl_next = 1'b0;
                    sda_next = shift_next[7];
                end
                PH_WR_H:
                begin
                    scl_next = 1'b1;
                end
                PH_WR_L:
                begin
                    scl_next = 1'b0;
                end
                PH_ACK_H:
                begin
                    sda_next  = 1'b1;
                    scl_next  = 1'b1;
                    unit_next = LONG_M1;
                end
                PH_RD_L:
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b1;
                end
                PH_RD_H:
                begin
                    scl_next   = 1'b1;
                    shift_next = {shift_next[6:0], sda_sample};
                end
                PH_AK_A:
                begin
                    scl_next = 1'b0;
                    sda_next = (cmd_reg == CMD_RDACK) ? 1'b0 : 1'b1;
                end
                PH_AK_B:
                begin
                    scl_next = 1'b1;
                end
                default:
                begin
                    unit_next = unit_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            cmd_reg   <= CMD_NONE;
            bit_reg   <= 4'd0;
            shift_reg <= 8'd0;
            delay_reg <= 16'd0;
            unit_reg  <= 3'd0;
            poll_reg  <= 8'd0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            rx_reg    <= 8'd0;
            err_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            delay_reg <= delay_next;
            unit_reg  <= unit_next;
            poll_reg  <= poll_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            rx_reg    <= rx_next;
            err_reg   <= err_next;
        end
    end

    // result of this tick
    always_comb
    begin
        res_next.scl_level    = scl_next;
        res_next.sda_released = sda_next;
        res_next.busy_res     = (phase_next != PH_IDLE);
        res_next.done_res     = fin;
        res_next.rx_byte      = rx_next;
        res_next.ack_error    = err_next;
    end

`ifndef SYNTHESIS
    // leaving a command always pulses done
    a_idle_done: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg != PH_IDLE && phase_next == PH_IDLE &&
         phase_reg != PH_POLL && delay_reg == 16'd0 && unit_reg == 3'd0) |-> fin)
        else $error("command left without done");

    // SCL is held high while polling for the ACK
    a_poll_scl: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_POLL) |-> scl_reg)
        else $error("SCL low during ACK poll");

    // bit counter never runs past a full byte
    a_bit_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> (bit_reg <= 4'd8))
        else $error("bit counter overflow");
`endif

endmodule

### tb/i2c_bit_level_master_tb.sv
`timescale 1ns / 1ps

module i2c_bit_level_master_tb;

    import i2cblm_pkg::*;

    // Modes outside the command set, ignored by an idle sequencer
    localparam logic [2:0] MODE_RSVD6 = 3'd6;
    localparam logic [2:0] MODE_RSVD7 = 3'd7;

    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_TICKS = 250;
    localparam int MAX_PRINTS   = 40;

    typedef struct {
        logic [2:0] mode;
        logic [7:0] tx;
        logic       sda;
    } tick_t;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = 16'd0;
    logic [2:0]  s_tuser  = CMD_NONE;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    // Stimulus and expectation stores
    tick_t tick_queue[$];
    res_t  expected_lines[$];
    tick_t next_tick;
    logic  in_taken = 1'b0;

    // Bookkeeping
    int  mismatches    = 0;
    int  stall_cycles  = 0;
    int  ticks_pushed  = 0;
    int  ticks_run     = 0;
    int  random_ticks  = 0;
    int  cmds_started  = 0;
    int  reads_done    = 0;
    int  ack_timeouts  = 0;
    int  reg_writes    = 0;
    int  noise_pct     = 0;
    bit  in_random     = 1'b0;
    bit  steady        = 1'b0;

    // Register mirrors
    logic [15:0] tpu_cfg = TICKS_RESET;
    logic [7:0]  lim_cfg = POLL_RESET;

    // Sequencer mirror
    phase_t      seq_ph    = PH_IDLE;
    logic [2:0]  seq_cmd   = CMD_NONE;
    logic [3:0]  seq_bits  = 4'd0;
    logic [7:0]  seq_shift = 8'd0;
    logic [15:0] seq_delay = 16'd0;
    logic [2:0]  seq_units = 3'd0;
    logic [7:0]  seq_polls = 8'd0;
    logic        scl_q     = 1'b1;
    logic        sda_q     = 1'b1;
    logic [7:0]  rx_q      = 8'd0;
    logic        err_q     = 1'b0;
    logic        done_q    = 1'b0;

    i2c_bit_level_master dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Sequencer prediction
    // ---------------------------------------------------------------

    // zero ticks per unit behaves as one
    function automatic logic [15:0] unit_ticks();
        return (tpu_cfg == 16'd0) ? 16'd1 : tpu_cfg;
    endfunction

    function automatic void hold_units(logic [2:0] n_m1);
        seq_units = n_m1;
        seq_delay = unit_ticks() - 16'd1;
    endfunction

    function automatic void finish_cmd();
        seq_ph = PH_IDLE;
        done_q = 1'b1;
    endfunction

    // Line levels are set on the first tick of each segment
    function automatic void enter_phase(phase_t p, logic smp);
        seq_ph = p;
        case (p)
            PH_ST_A:
            begin
                sda_q = 1'b1;
                scl_q = 1'b1;
                hold_units(LONG_M1);
            end
            PH_ST_B:
            begin
                sda_q = 1'b0;
                hold_units(LONG_M1);
            end
            PH_SP_A:
            begin
                scl_q = 1'b0;
                sda_q = 1'b0;
                hold_units(LONG_M1);
            end
            PH_SP_B:
            begin
                scl_q = 1'b1;
                sda_q = 1'b1;
                hold_units(LONG_M1);
            end
            PH_WR_D:
            begin
                scl_q = 1'b0;
                sda_q = seq_shift[7];
                hold_units(SHORT_M1);
            end
            PH_WR_H:
            begin
                scl_q = 1'b1;
                hold_units(SHORT_M1);
            end
            PH_WR_L:
            begin
                scl_q = 1'b0;
                hold_units(SHORT_M1);
            end
            PH_ACK_H:
            begin
                sda_q = 1'b1;
                scl_q = 1'b1;
                hold_units(LONG_M1);
            end
            PH_RD_L:
            begin
                scl_q = 1'b0;
                sda_q = 1'b1;
                hold_units(SHORT_M1);
            end
            PH_RD_H:
            begin
                // data is captured on the first SCL-high tick
                scl_q = 1'b1;
                seq_shift = {seq_shift[6:0], smp};
                hold_units(SHORT_M1);
            end
            PH_AK_A:
            begin
                scl_q = 1'b0;
                sda_q = (seq_cmd == CMD_RDACK) ? 1'b0 : 1'b1;
                hold_units(SHORT_M1);
            end
            PH_AK_B:
            begin
                scl_q = 1'b1;
                hold_units(SHORT_M1);
            end
            default: seq_ph = PH_IDLE;
        endcase
    endfunction

    // One ACK poll: low ends the write, too many highs abort with a stop
    function automatic void poll_ack(logic smp);
        if (!smp)
        begin
            scl_q = 1'b0;
            finish_cmd();
        end
        else if (seq_polls >= lim_cfg)
        begin
            err_q = 1'b1;
            ack_timeouts++;
            enter_phase(PH_SP_A, smp);
        end
        else
            seq_polls++;
    endfunction

    function automatic void end_segment(logic smp);
        case (seq_ph)
            PH_ST_A: enter_phase(PH_ST_B, smp);
            PH_ST_B:
            begin
                scl_q = 1'b0;
                finish_cmd();
            end
            PH_SP_A: enter_phase(PH_SP_B, smp);
            PH_SP_B: finish_cmd();
            PH_WR_D: enter_phase(PH_WR_H, smp);
            PH_WR_H: enter_phase(PH_WR_L, smp);
            PH_WR_L:
            begin
                seq_bits  = seq_bits + 4'd1;
                seq_shift = {seq_shift[6:0], 1'b0};
                enter_phase((seq_bits >= 4'd8) ? PH_ACK_H : PH_WR_D, smp);
            end
            PH_ACK_H:
            begin
                seq_ph    = PH_POLL;
                seq_polls = 8'd0;
                poll_ack(smp);
            end
            PH_RD_L: enter_phase(PH_RD_H, smp);
            PH_RD_H:
            begin
                seq_bits = seq_bits + 4'd1;
                enter_phase((seq_bits >= 4'd8) ? PH_AK_A : PH_RD_L, smp);
            end
            PH_AK_A: enter_phase(PH_AK_B, smp);
            PH_AK_B:
            begin
                scl_q = 1'b0;
                rx_q  = seq_shift;
                reads_done++;
                finish_cmd();
            end
            default: seq_ph = PH_IDLE;
        endcase
    endfunction

    // Advance the mirror by one tick and return the line state after it
    function automatic res_t sequencer_tick(logic [2:0] mode, logic [7:0] tx, logic smp);
        res_t r;
        done_q = 1'b0;
        if (seq_ph == PH_IDLE)
        begin
            if (mode >= CMD_START && mode <= CMD_RDNAK)
            begin
                seq_cmd  = mode;
                seq_bits = 4'd0;
                cmds_started++;
                case (mode)
                    CMD_START: enter_phase(PH_ST_A, smp);
                    CMD_STOP:  enter_phase(PH_SP_A, smp);
                    CMD_WRITE:
                    begin
                        seq_shift = tx;
                        err_q     = 1'b0;
                        enter_phase(PH_WR_D, smp);
                    end
                    default:
                    begin
                        seq_shift = 8'd0;
                        enter_phase(PH_RD_L, smp);
                    end
                endcase
            end
        end
        else if (seq_ph == PH_POLL)
            poll_ack(smp);
        else if (seq_delay != 16'd0)
            seq_delay--;
        else if (seq_units != 3'd0)
        begin
            seq_units--;
            seq_delay = unit_ticks() - 16'd1;
        end
        else
            end_segment(smp);

        r.scl_level    = scl_q;
        r.sda_released = sda_q;
        r.busy_res     = (seq_ph != PH_IDLE);
        r.done_res     = done_q;
        r.rx_byte      = rx_q;
        r.ack_error    = err_q;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch at %0t ns: %s got 0x%0h want 0x%0h", $time, what, got, want);
    endtask

    task automatic compare_result(logic [15:0] word, res_t want);
        res_t got = res_t'(word[12:0]);
        if (got.scl_level !== want.scl_level)
            report_mismatch("scl_level", got.scl_level, want.scl_level);
        if (got.sda_released !== want.sda_released)
            report_mismatch("sda_released", got.sda_released, want.sda_released);
        if (got.busy_res !== want.busy_res)
            report_mismatch("busy_res", got.busy_res, want.busy_res);
        if (got.done_res !== want.done_res)
            report_mismatch("done_res", got.done_res, want.done_res);
        if (got.rx_byte !== want.rx_byte)
            report_mismatch("rx_byte", got.rx_byte, want.rx_byte);
        if (got.ack_error !== want.ack_error)
            report_mismatch("ack_error", got.ack_error, want.ack_error);
        if (word[15:13] !== 3'd0)
            report_mismatch("m_tdata pad", word[15:13], 0);
    endtask

    // ---------------------------------------------------------------
    // Driver and monitor
    // ---------------------------------------------------------------

    function automatic bit take_gap();
        return !steady && ($urandom_range(99) < 7);
    endfunction

    // Inputs change on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || in_taken)
            begin
                if (!take_gap() && tick_queue.size() != 0)
                begin
                    next_tick = tick_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {7'd0, next_tick.sda, next_tick.tx};
                    s_tuser  <= next_tick.mode;
                end
                else
                    s_tvalid <= 1'b0;
            end
            m_tready <= !take_gap();
        end
    end

    // Results are checked before the new word is predicted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            in_taken <= s_tvalid && s_tready;
            if (m_tvalid && m_tready)
            begin
                if (expected_lines.size() == 0)
                    report_mismatch("result with nothing expected", m_tdata, 0);
                else
                    compare_result(m_tdata, expected_lines.pop_front());
            end
            if (s_tvalid && s_tready)
            begin
                expected_lines.push_back(sequencer_tick(s_tuser, s_tdata[7:0], s_tdata[8]));
                ticks_run++;
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
    end

    // Watchdog on cycles where neither side moves a word
    always @(negedge clk)
    begin
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("i2c_bit_level_master_tb: done, errors");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    // pct is the chance in percent that the sampled SDA is high
    task automatic push_tick(logic [2:0] mode, logic [7:0] tx, int pct);
        tick_t t;
        t.mode = mode;
        t.tx   = tx;
        t.sda  = ($urandom_range(99) < pct);
        tick_queue.push_back(t);
        ticks_pushed++;
        if (in_random)
            random_ticks++;
    endtask

    // Feed filler ticks until the sequencer is idle with nothing in flight
    task automatic run_until_idle(int pct);
        int chunk_len;
        while (!(ticks_pushed == ticks_run && seq_ph == PH_IDLE))
        begin
            if (seq_ph != PH_IDLE && tick_queue.size() == 0)
            begin
                chunk_len = (tpu_cfg > 16'd8) ? 64 : 4;
                for (int k = 0; k < chunk_len; k++)
                begin
                    if (noise_pct != 0 && $urandom_range(99) < noise_pct)
                        push_tick(3'($urandom_range(7)), 8'($urandom), pct);
                    else
                        push_tick(CMD_NONE, 8'($urandom), pct);
                end
            end
            @(negedge clk);
        end
    endtask

    task automatic issue(logic [2:0] mode, logic [7:0] tx, int pct);
        push_tick(mode, tx, pct);
        run_until_idle(pct);
    endtask

    // Sender holds off until every result is back
    task automatic settle();
        run_until_idle(50);
        while (expected_lines.size() != 0)
            @(negedge clk);
    endtask

    // APB write, then read back
    task automatic set_register(logic idx, logic [15:0] val);
        logic [31:0] want;
        want = (idx == REG_TICKS) ? {16'd0, val} : {24'd0, val[7:0]};
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= want;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == REG_TICKS)
            tpu_cfg = val;
        else
            lim_cfg = val[7:0];
        reg_writes++;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== want)
            report_mismatch(idx == REG_TICKS ? "ticks register readback"
                                             : "poll register readback", prdata, want);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic int pick_pct();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 50;
            2:       return 90;
            default: return 100;
        endcase
    endfunction

    // Mostly well-formed transfers, now and then a lone random command
    task automatic random_transfer();
        int n;
        if ($urandom_range(4) == 0)
        begin
            issue(3'($urandom_range(7)), 8'($urandom), pick_pct());
            return;
        end
        issue(CMD_START, 8'($urandom), pick_pct());
        issue(CMD_WRITE, 8'($urandom), pick_pct());
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++)
        begin
            case ($urandom_range(2))
                0:       issue(CMD_WRITE, 8'($urandom), pick_pct());
                1:       issue(CMD_RDACK, 8'($urandom), pick_pct());
                default: issue(CMD_RDNAK, 8'($urandom), pick_pct());
            endcase
        end
        issue(CMD_STOP, 8'($urandom), pick_pct());
    endtask

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial
    begin
        int round;
        logic [15:0] tpu_pick;
        logic [15:0] lim_pick;
        round = 0;

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // reset settings: 50 ticks per unit, poll limit 250
        issue(CMD_START, 8'h00, 50);
        settle();

        // zero ticks per unit, zero poll limit
        set_register(REG_TICKS, 16'd0);
        set_register(REG_POLL, 16'd0);
        issue(CMD_NONE, 8'hFF, 100);
        issue(MODE_RSVD6, 8'h00, 0);
        issue(MODE_RSVD7, 8'hFF, 100);
        issue(CMD_START, 8'h00, 0);
        issue(CMD_WRITE, 8'h00, 0);        // immediate ACK
        issue(CMD_WRITE, 8'hFF, 100);      // first high poll times out
        issue(CMD_RDACK, 8'h00, 100);      // reads 0xFF, error flag kept
        issue(CMD_WRITE, 8'h5A, 0);        // error cleared by the next write
        issue(CMD_RDNAK, 8'hFF, 0);        // reads 0x00
        issue(CMD_STOP, 8'h00, 50);
        settle();

        // one tick per unit, maximum poll limit, no idling
        steady = 1'b1;
        set_register(REG_TICKS, 16'd1);
        set_register(REG_POLL, 16'd255);
        issue(CMD_START, 8'h81, 50);
        issue(CMD_WRITE, 8'hA5, 100);      // full 256-poll timeout
        issue(CMD_WRITE, 8'h3C, 90);
        issue(CMD_RDACK, 8'h00, 50);
        noise_pct = 30;                    // commands thrown at a busy block
        issue(CMD_WRITE, 8'hC3, 90);
        issue(CMD_RDNAK, 8'h7E, 50);
        noise_pct = 0;
        issue(CMD_STOP, 8'h00, 50);
        settle();

        // largest unit: register write and readback only
        set_register(REG_TICKS, 16'hFFFF);
        set_register(REG_POLL, 16'd1);
        steady = 1'b0;

        // random transfers over a spread of settings
        in_random = 1'b1;
        noise_pct = 8;
        while (random_ticks < RANDOM_TICKS)
        begin
            settle();
            case ($urandom_range(4))
                0:       tpu_pick = 16'd0;
                1:       tpu_pick = 16'd1;
                2:       tpu_pick = 16'd2;
                3:       tpu_pick = 16'd3;
                default: tpu_pick = 16'($urandom_range(1, 5));
            endcase
            case ($urandom_range(5))
                0:       lim_pick = 16'd0;
                1:       lim_pick = 16'd1;
                2:       lim_pick = 16'($urandom_range(2, 6));
                3:       lim_pick = 16'($urandom_range(1, 30));
                4:       lim_pick = 16'd255;
                default: lim_pick = 16'($urandom_range(0, 255));
            endcase
            set_register(REG_TICKS, tpu_pick);
            set_register(REG_POLL, lim_pick);
            steady = (round == 1);
            random_transfer();
            round++;
        end
        steady = 1'b0;
        settle();
        repeat (4) @(posedge clk);

        $display("i2c_bit_level_master_tb: %0d ticks, %0d commands, %0d reads, %0d timeouts",
                 ticks_run, cmds_started, reads_done, ack_timeouts);
        $display("i2c_bit_level_master_tb: %0d reg writes, %0d random rounds, %0d mismatches",
                 reg_writes, round, mismatches);
        if (mismatches == 0)
            $display("i2c_bit_level_master_tb: done, clean");
        else
            $display("i2c_bit_level_master_tb: done, errors");
        $finish;
    end

endmodule
